FILE: hdl/vqde_pkg.sv
// Shared types, constants and codes of the virtqueue device-side engine.
`default_nettype none
package vqde_pkg;

    localparam int QUEUE_SIZE = 64;
    localparam int QUEUE_LOG2 = $clog2(QUEUE_SIZE);
    localparam int QIDX_W     = 6;
    localparam int CNT_W      = 7;
    localparam int ADDR_W     = 64;
    localparam int LEN_W      = 32;
    localparam int FLAG_W     = 16;
    localparam int IDX_W      = 16;
    localparam int ULEN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_LOG2   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUEST_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_SIZE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_BASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_MODE = 3'd4;

    typedef enum logic [2:0] {
        OP_WRITE_DESC = 3'd0,
        OP_PUBLISH    = 3'd1,
        OP_POLL       = 3'd2,
        OP_COMPLETE   = 3'd3,
        OP_READ_USED  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RESP,
        S_HEAD,
        S_P1_FETCH,
        S_P1_EVAL,
        S_P2_FETCH,
        S_P2_EMIT
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [FLAG_W-1:0] flags;
        logic [QIDX_W-1:0] next;
    } desc_t;

    typedef struct packed {
        logic [QIDX_W-1:0] id;
        logic [ULEN_W-1:0] len;
    } used_t;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic dispatch;
        logic resp_load;
        logic head_load;
        logic p1_eval;
        logic p2_emit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic req_valid;
        logic go_poll;
        logic p1_done;
        logic p2_last;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: hdl/vqde_if.sv
// Request and result channel interfaces.
`default_nettype none
interface vqde_in_if;
    import vqde_pkg::*;
    logic                valid;
    logic                ready;
    logic [2:0]          opcode;
    logic [QIDX_W-1:0]   slot;
    logic [ADDR_W-1:0]   guest_addr;
    logic [LEN_W-1:0]    buf_len;
    logic [FLAG_W-1:0]   desc_flags_in;
    logic [QIDX_W-1:0]   next_slot;
    logic [CNT_W-1:0]    chain_len_in;
    modport source (output valid, opcode, slot, guest_addr, buf_len, desc_flags_in,
                    next_slot, chain_len_in, input ready);
    modport sink (input valid, opcode, slot, guest_addr, buf_len, desc_flags_in,
                  next_slot, chain_len_in, output ready);
endinterface

interface vqde_out_if;
    import vqde_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [QIDX_W-1:0]   head_id;
    logic [ADDR_W-1:0]   host_addr;
    logic [LEN_W-1:0]    out_len;
    logic [FLAG_W-1:0]   out_flags;
    logic [CNT_W-1:0]    chain_count;
    logic [IDX_W-1:0]    used_head_index;
    logic [CNT_W-1:0]    avail_pending;
    logic                last;
    modport source (output valid, status, head_id, host_addr, out_len, out_flags,
                    chain_count, used_head_index, avail_pending, last, input ready);
    modport sink (input valid, status, head_id, host_addr, out_len, out_flags,
                  chain_count, used_head_index, avail_pending, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/vqde_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vqde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/vqde_ctrl.sv
// Sequencing state machine of the engine.
`default_nettype none
module vqde_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire vqde_pkg::dp_stat_t   stat,
    output vqde_pkg::ctrl_cmd_t       cmd
);
    import vqde_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                state_next   = stat.go_poll ? S_HEAD : S_RESP;
            end
            S_RESP:
            begin
                cmd.resp_load = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_HEAD:
            begin
                cmd.head_load = 1'b1;
                state_next    = S_P1_FETCH;
            end
            S_P1_FETCH:
            begin
                state_next = S_P1_EVAL;
            end
            S_P1_EVAL:
            begin
                cmd.p1_eval = 1'b1;
                if (stat.p1_done)
                begin
                    state_next = S_P2_FETCH;
                end
            end
            S_P2_FETCH:
            begin
                state_next = S_P2_EMIT;
            end
            S_P2_EMIT:
            begin
                cmd.p2_emit = stat.out_free;
                if (stat.out_free && stat.p2_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/vqde_dp.sv
// Datapath: configuration, rings, descriptor table, chain walk and result register.
`default_nettype none
module vqde_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [vqde_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vqde_pkg::CFG_DATA_W-1:0]  cfg_data,
    vqde_in_if.sink                               req,
    vqde_out_if.source                            rsp,
    input  wire vqde_pkg::ctrl_cmd_t              cmd,
    output vqde_pkg::dp_stat_t                    stat
);
    import vqde_pkg::*;

    // configuration
    logic [2:0]        lg_cfg_reg;
    logic [ADDR_W-1:0] gbase_reg, wsize_reg, hbase_reg;
    logic              worker_reg;

    // captured item
    op_t               op_reg;
    logic [QIDX_W-1:0] slot_reg;
    logic [ADDR_W-1:0] gaddr_reg;
    logic [LEN_W-1:0]  blen_reg;
    logic [FLAG_W-1:0] dflags_reg;
    logic [QIDX_W-1:0] nslot_reg;
    logic [CNT_W-1:0]  clen_reg;

    // queue state
    logic [IDX_W-1:0]      awi_reg, ari_reg, uwi_reg;
    logic [CNT_W-1:0]      biu_reg;
    logic [QUEUE_SIZE-1:0] uvld_reg;
    logic                  uvld_q_reg;

    // walk state
    logic [QIDX_W-1:0] head_reg, d_reg;
    logic [CNT_W-1:0]  cnt_reg, len_reg;
    status_t           st_reg;

    // result register
    logic              ov_reg;
    logic [1:0]        o_status_reg;
    logic [QIDX_W-1:0] o_head_reg;
    logic [ADDR_W-1:0] o_host_reg;
    logic [LEN_W-1:0]  o_len_reg;
    logic [FLAG_W-1:0] o_flags_reg;
    logic [CNT_W-1:0]  o_count_reg;
    logic [IDX_W-1:0]  o_uidx_reg;
    logic [CNT_W-1:0]  o_pend_reg;
    logic              o_last_reg;

    logic [2:0]        lg;
    logic [CNT_W-1:0]  size;
    logic [QIDX_W-1:0] mask;
    logic [IDX_W-1:0]  pending;
    logic              pend_full;
    op_t               req_op;

    desc_t             rdesc, wdesc;
    logic [QIDX_W-1:0] desc_raddr;
    logic              desc_we;
    logic [QIDX_W-1:0] avail_rdata;
    logic              avail_we;
    used_t             used_rdata, used_wdata;
    logic              used_we;

    logic [CNT_W-1:0]  c;
    logic [CNT_W:0]    biu_probe;
    logic              pool_fail, long_fail, chain_end, p1_done, chain_ok;
    logic              p2_last, advance;
    logic [QIDX_W-1:0] next_d;
    logic [CNT_W-1:0]  n_clamp;
    logic [ADDR_W-1:0] off, host;
    logic              out_free;

    always_comb
    begin
        if (lg_cfg_reg == 3'd0)
        begin
            lg = 3'd1;
        end
        else if (lg_cfg_reg > 3'(QUEUE_LOG2))
        begin
            lg = 3'(QUEUE_LOG2);
        end
        else
        begin
            lg = lg_cfg_reg;
        end
    end

    assign size      = CNT_W'(1) << lg;
    assign mask      = QIDX_W'(size - CNT_W'(1));
    assign pending   = awi_reg - ari_reg;
    assign pend_full = pending >= IDX_W'(size);
    assign req_op    = op_t'(req.opcode);

    // chain walk step
    assign c         = cnt_reg + CNT_W'(1);
    assign biu_probe = {1'b0, biu_reg} + {1'b0, c} - (CNT_W+1)'(1);
    assign pool_fail = biu_probe >= {1'b0, size};
    assign long_fail = rdesc.flags[0] && (c >= size);
    assign chain_end = !rdesc.flags[0];
    assign p1_done   = pool_fail || long_fail || chain_end;
    assign chain_ok  = !pool_fail && !long_fail;
    assign p2_last   = (c == len_reg);
    assign next_d    = rdesc.next & mask;
    assign advance   = (cmd.p1_eval && !p1_done) || (cmd.p2_emit && !p2_last);
    assign desc_raddr = advance ? next_d : d_reg;

    assign n_clamp = (clen_reg > size) ? size : clen_reg;

    // window translation
    assign off  = rdesc.addr - gbase_reg;
    assign host = ((rdesc.addr >= gbase_reg) && (off < wsize_reg)) ? hbase_reg + off : '0;

    assign out_free = !ov_reg || rsp.ready;

    assign stat.req_valid = req.valid;
    assign stat.go_poll   = (op_reg == OP_POLL) && (pending != '0);
    assign stat.p1_done   = p1_done;
    assign stat.p2_last   = p2_last;
    assign stat.out_free  = out_free;
    assign req.ready      = cmd.in_ready;

    // memories
    assign desc_we = cmd.dispatch && (op_reg == OP_WRITE_DESC);
    assign wdesc   = '{addr: gaddr_reg, len: blen_reg, flags: dflags_reg, next: nslot_reg};

    vqde_ram #(.WIDTH($bits(desc_t)), .DEPTH(QUEUE_SIZE)) u_desc_ram (
        .clk   (clk),
        .we    (desc_we),
        .waddr (slot_reg),
        .wdata (wdesc),
        .raddr (desc_raddr),
        .rdata (rdesc)
    );

    assign avail_we = cmd.dispatch && (op_reg == OP_PUBLISH) && !pend_full;

    vqde_ram #(.WIDTH(QIDX_W), .DEPTH(QUEUE_SIZE)) u_avail_ram (
        .clk   (clk),
        .we    (avail_we),
        .waddr (awi_reg[QIDX_W-1:0] & mask),
        .wdata (slot_reg),
        .raddr (ari_reg[QIDX_W-1:0] & mask),
        .rdata (avail_rdata)
    );

    assign used_we = (cmd.dispatch && (op_reg == OP_COMPLETE))
                   || (cmd.p1_eval && p1_done && chain_ok && !worker_reg);
    assign used_wdata = cmd.dispatch ? used_t'{id: slot_reg, len: ULEN_W'(n_clamp)}
                                     : used_t'{id: head_reg, len: ULEN_W'(c)};

    vqde_ram #(.WIDTH($bits(used_t)), .DEPTH(QUEUE_SIZE)) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (uwi_reg[QIDX_W-1:0] & mask),
        .wdata (used_wdata),
        .raddr (slot_reg),
        .rdata (used_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        uvld_q_reg <= uvld_reg[slot_reg];
        if (cmd.in_ready && req.valid)
        begin
            op_reg     <= req_op;
            slot_reg   <= req.slot & mask;
            gaddr_reg  <= req.guest_addr;
            blen_reg   <= req.buf_len;
            dflags_reg <= req.desc_flags_in;
            nslot_reg  <= req.next_slot;
            clen_reg   <= req.chain_len_in;
        end
        if (cmd.dispatch)
        begin
            if (op_reg == OP_PUBLISH && pend_full)
            begin
                st_reg <= ST_EXHAUSTED;
            end
            else if (op_reg == OP_POLL && pending == '0)
            begin
                st_reg <= ST_EMPTY;
            end
            else
            begin
                st_reg <= ST_OK;
            end
            len_reg <= n_clamp;
        end
        if (cmd.head_load)
        begin
            head_reg <= avail_rdata & mask;
            d_reg    <= avail_rdata & mask;
            cnt_reg  <= '0;
        end
        if (cmd.p1_eval)
        begin
            if (p1_done)
            begin
                len_reg <= c;
                st_reg  <= pool_fail ? ST_EXHAUSTED : (long_fail ? ST_TOO_LONG : ST_OK);
                d_reg   <= head_reg;
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= c;
                d_reg   <= next_d;
            end
        end
        if (cmd.p2_emit)
        begin
            cnt_reg <= c;
            d_reg   <= next_d;
        end
        if (cmd.resp_load)
        begin
            o_status_reg <= st_reg;
            o_host_reg   <= '0;
            o_flags_reg  <= '0;
            o_last_reg   <= 1'b1;
            o_uidx_reg   <= uwi_reg;
            o_pend_reg   <= pending[CNT_W-1:0];
            unique case (op_reg)
                OP_WRITE_DESC, OP_PUBLISH:
                begin
                    o_head_reg  <= slot_reg;
                    o_len_reg   <= '0;
                    o_count_reg <= '0;
                end
                OP_COMPLETE:
                begin
                    o_head_reg  <= slot_reg;
                    o_len_reg   <= LEN_W'(len_reg);
                    o_count_reg <= len_reg;
                end
                OP_READ_USED:
                begin
                    if (uvld_q_reg)
                    begin
                        o_head_reg  <= used_rdata.id;
                        o_len_reg   <= LEN_W'(used_rdata.len);
                        o_count_reg <= used_rdata.len[CNT_W-1:0];
                    end
                    else
                    begin
                        o_head_reg  <= '0;
                        o_len_reg   <= '0;
                        o_count_reg <= '0;
                    end
                end
                // empty poll and unknown opcodes
                default:
                begin
                    o_head_reg  <= '0;
                    o_len_reg   <= '0;
                    o_count_reg <= '0;
                end
            endcase
        end
        if (cmd.p2_emit)
        begin
            o_status_reg <= p2_last ? st_reg : ST_OK;
            o_head_reg   <= head_reg;
            o_host_reg   <= host;
            o_len_reg    <= rdesc.len;
            o_flags_reg  <= rdesc.flags;
            o_count_reg  <= c;
            o_uidx_reg   <= uwi_reg;
            o_pend_reg   <= pending[CNT_W-1:0];
            o_last_reg   <= p2_last;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_cfg_reg <= 3'(QUEUE_LOG2);
            gbase_reg  <= '0;
            wsize_reg  <= '0;
            hbase_reg  <= '0;
            worker_reg <= 1'b0;
            awi_reg    <= '0;
            ari_reg    <= '0;
            uwi_reg    <= '0;
            biu_reg    <= '0;
            uvld_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RING_LOG2:   lg_cfg_reg <= cfg_data[2:0];
                    CFG_GUEST_BASE:  gbase_reg  <= cfg_data;
                    CFG_WIN_SIZE:    wsize_reg  <= cfg_data;
                    CFG_HOST_BASE:   hbase_reg  <= cfg_data;
                    CFG_WORKER_MODE: worker_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
            if (avail_we)
            begin
                awi_reg <= awi_reg + IDX_W'(1);
            end
            if (cmd.head_load)
            begin
                ari_reg <= ari_reg + IDX_W'(1);
            end
            if (used_we)
            begin
                uwi_reg <= uwi_reg + IDX_W'(1);
                uvld_reg[uwi_reg[QIDX_W-1:0] & mask] <= 1'b1;
            end
            if (cmd.dispatch && op_reg == OP_COMPLETE)
            begin
                biu_reg <= (n_clamp > biu_reg) ? '0 : biu_reg - n_clamp;
            end
            if (cmd.p1_eval && p1_done && chain_ok && worker_reg)
            begin
                biu_reg <= biu_reg + c;
            end
            if (cmd.resp_load || cmd.p2_emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid           = ov_reg;
    assign rsp.status          = o_status_reg;
    assign rsp.head_id         = o_head_reg;
    assign rsp.host_addr       = o_host_reg;
    assign rsp.out_len         = o_len_reg;
    assign rsp.out_flags       = o_flags_reg;
    assign rsp.chain_count     = o_count_reg;
    assign rsp.used_head_index = o_uidx_reg;
    assign rsp.avail_pending   = o_pend_reg;
    assign rsp.last            = o_last_reg;
endmodule
`default_nettype wire

FILE: hdl/virtqueue_device_side_engine_top.sv
// Top level of the virtqueue device-side engine.
//
// Channels: req carries one command item (write descriptor, publish head, poll,
// complete, read used entry); rsp returns result items, the final one of each
// command marked by last. Handshake: an item moves on a clock edge with valid
// and ready high. Configuration: cfg_we/cfg_index/cfg_data, write only. The
// user must see that it is written only while the engine is idle; the block
// does not enforce this. A non-poll command gives its single result by
// dispatch, then a load into the result register once that can take it; the
// next item goes in only after the engine is back in idle.
// A poll of a chain of L descriptors walks the descriptor table twice, one
// RAM read per descriptor per pass: a first pass settles the outcome and ring
// updates, a second emits one result per descriptor, one per cycle while the
// receiver takes them; the next item goes in only after the last result.
// Items are handled one at a time; req.ready is high only while idle.
// Reset: indices, pool count and used-ring valid bits clear at once; the
// descriptor table and available ring hold garbage until written. No
// clearing pass, so the engine is ready right after reset.
// A stalled receiver holds the result register; the walk waits in place.
`default_nettype none
module virtqueue_device_side_engine_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [vqde_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vqde_pkg::CFG_DATA_W-1:0]  cfg_data,
    vqde_in_if.sink                               req,
    vqde_out_if.source                            rsp
);
    import vqde_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer: decides what the datapath does each cycle
    vqde_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // rings, descriptor table, translation and result register
    vqde_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );
endmodule
`default_nettype wire

FILE: hdl/vqde_checker.sv
// Port-level checks of the engine, bound to the top level.
`default_nettype none
module vqde_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [1:0] rsp_status,
    input wire logic [6:0] rsp_count,
    input wire logic [6:0] rsp_pending,
    input wire logic       rsp_last
);
    // one item at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last))
        else $error("stalled result changed");

    a_empty_poll: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == 2'd1 |-> rsp_last && rsp_count == 7'd0)
        else $error("empty poll result malformed");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_pending <= 7'd64)
        else $error("pending count exceeds ring");
endmodule

bind virtqueue_device_side_engine_top vqde_checker u_vqde_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_count   (rsp.chain_count),
    .rsp_pending (rsp.avail_pending),
    .rsp_last    (rsp.last)
);
`default_nettype wire
